@@ rtl/core/lzw_pkg.sv @@
// shared constants and types of the lzw byte encoder
`default_nettype none

package lzw_pkg;

  // fixed field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 12;

  // defaults for the top level parameters
  localparam int unsigned DefCodeBits   = 12;
  localparam int unsigned DefSymbolCount = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_LAST
  } state_e;

  // status of the dictionary search unit
  typedef struct packed {
    logic done;
    logic hit;
  } scan_status_t;

endpackage

`default_nettype wire

@@ rtl/core/lzw_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module lzw_ram
  import lzw_pkg::*;
#(
  parameter int unsigned WIDTH = DefCodeBits + ByteW,
  parameter int unsigned DEPTH = 1 << DefCodeBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/lzw_scan.sv @@
// dictionary search: walks the entries one per cycle with a single comparator
`default_nettype none

module lzw_scan
  import lzw_pkg::*;
#(
  parameter int unsigned CODE_BITS    = DefCodeBits,
  parameter int unsigned SYMBOL_COUNT = DefSymbolCount
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [CODE_BITS:0]        limit_i,
  input  wire logic [CODE_BITS+ByteW-1:0] key_i,
  output logic                           rd_en_o,
  output logic      [CODE_BITS-1:0]      rd_addr_o,
  input  wire logic [CODE_BITS+ByteW-1:0] rd_data_i,
  output scan_status_t                   status_o,
  output logic      [CODE_BITS-1:0]      hit_code_o
);

  localparam logic [CODE_BITS:0] FirstCode = (CODE_BITS+1)'(SYMBOL_COUNT);

  logic                 busy_q, busy_d;
  logic [CODE_BITS:0]   scan_addr_q, scan_addr_d;
  logic                 cmp_valid_q, cmp_valid_d;
  logic [CODE_BITS-1:0] cmp_addr_q, cmp_addr_d;
  logic                 match;
  logic                 issue;

  always_comb begin
    match       = busy_q && cmp_valid_q && (rd_data_i == key_i);
    issue       = busy_q && !match && (scan_addr_q < limit_i);
    busy_d      = busy_q;
    scan_addr_d = scan_addr_q;
    cmp_valid_d = cmp_valid_q;
    cmp_addr_d  = cmp_addr_q;
    if (start_i) begin
      busy_d      = 1'b1;
      scan_addr_d = FirstCode;
      cmp_valid_d = 1'b0;
    end else if (busy_q) begin
      cmp_valid_d = issue;
      if (issue) begin
        cmp_addr_d  = scan_addr_q[CODE_BITS-1:0];
        scan_addr_d = scan_addr_q + 1'b1;
      end else begin
        // either a hit or every entry below the limit missed
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cmp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    cmp_addr_q  <= cmp_addr_d;
  end

  assign rd_en_o       = issue;
  assign rd_addr_o     = scan_addr_q[CODE_BITS-1:0];
  assign status_o.done = busy_q && !issue;
  assign status_o.hit  = match;
  assign hit_code_o    = cmp_addr_q;

endmodule

`default_nettype wire

@@ rtl/core/lzw_byte_encoder_top.sv @@
// lzw byte encoder top level: phrase control, dictionary ram and output register
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i in_stall_o in_byte_i in_last_i | input
//   out     | out_valid_o out_stall_i code_o out_last_o | output
//
// a byte with no phrase held becomes the phrase (and is emitted when last).
// otherwise the search unit reads one dictionary entry per cycle from the ram,
// from SYMBOL_COUNT up to the next free code, stopping at the first hit;
// a miss then goes through the emit step.
// reset needs no clearing pass: only entries below the next free code are read.
// a full output register holds the sequencer in its emit step until taken.
`default_nettype none

module lzw_byte_encoder_top
  import lzw_pkg::*;
#(
  parameter int unsigned CODE_BITS    = DefCodeBits,
  parameter int unsigned SYMBOL_COUNT = DefSymbolCount
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             in_last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [CodeW-1:0] code_o,
  output logic                  out_last_o
);

  localparam int unsigned EntryW = CODE_BITS + ByteW;
  localparam int unsigned ExtW   = CODE_BITS + CodeW;
  localparam logic [CODE_BITS:0] FirstCode = (CODE_BITS+1)'(SYMBOL_COUNT);
  localparam logic [ByteW:0]     SymCount  = (ByteW+1)'(SYMBOL_COUNT);
  localparam logic [ByteW-1:0]   SymMax    = ByteW'(SYMBOL_COUNT - 1);

  state_e               state_q, state_d;
  logic [CODE_BITS-1:0] phrase_code_q, phrase_code_d;
  logic                 phrase_valid_q, phrase_valid_d;
  logic [CODE_BITS:0]   next_free_q, next_free_d;
  logic [ByteW-1:0]     byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [CodeW-1:0]     out_code_q, out_code_d;
  logic                 out_last_q, out_last_d;

  logic                 in_beat;
  logic                 out_free;
  logic [ByteW-1:0]     sat_byte;
  logic [ExtW-1:0]      phrase_ext;
  logic                 scan_start;
  logic                 wr_en;
  logic                 rd_en;
  logic [CODE_BITS-1:0] rd_addr;
  logic [EntryW-1:0]    rd_data;
  scan_status_t         scan_status;
  logic [CODE_BITS-1:0] hit_code;

  lzw_ram #(
    .WIDTH (EntryW),
    .DEPTH (1 << CODE_BITS)
  ) u_dict (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (next_free_q[CODE_BITS-1:0]),
    .wr_data_i ({phrase_code_q, byte_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lzw_scan #(
    .CODE_BITS    (CODE_BITS),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .limit_i    (next_free_q),
    .key_i      ({phrase_code_q, byte_q}),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .status_o   (scan_status),
    .hit_code_o (hit_code)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sat_byte   = ({1'b0, in_byte_i} >= SymCount) ? SymMax : in_byte_i;
  assign phrase_ext = ExtW'(phrase_code_q);

  always_comb begin
    state_d        = state_q;
    phrase_code_d  = phrase_code_q;
    phrase_valid_d = phrase_valid_q;
    next_free_d    = next_free_q;
    byte_d         = byte_q;
    last_d         = last_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_code_d     = out_code_q;
    out_last_d     = out_last_q;
    scan_start     = 1'b0;
    wr_en          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          byte_d = sat_byte;
          last_d = in_last_i;
          if (!phrase_valid_q) begin
            // stream start: the byte itself becomes the phrase
            phrase_code_d  = CODE_BITS'(sat_byte);
            phrase_valid_d = 1'b1;
            state_d        = in_last_i ? ST_LAST : ST_IDLE;
          end else begin
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_status.done) begin
          if (scan_status.hit) begin
            phrase_code_d = hit_code;
            state_d       = last_q ? ST_LAST : ST_IDLE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_code_d    = phrase_ext[CodeW-1:0];
          out_last_d    = 1'b0;
          // add the new entry while the dictionary has room
          wr_en         = !next_free_q[CODE_BITS];
          if (!next_free_q[CODE_BITS]) begin
            next_free_d = next_free_q + 1'b1;
          end
          phrase_code_d = CODE_BITS'(byte_q);
          state_d       = last_q ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_code_d     = phrase_ext[CodeW-1:0];
          out_last_d     = 1'b1;
          phrase_valid_d = 1'b0;
          phrase_code_d  = '0;
          next_free_d    = FirstCode;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phrase_code_q  <= '0;
      phrase_valid_q <= 1'b0;
      next_free_q    <= FirstCode;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      phrase_code_q  <= phrase_code_d;
      phrase_valid_q <= phrase_valid_d;
      next_free_q    <= next_free_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    last_q     <= last_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = out_code_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
